// ----- design/assert_macros.svh -----
// Assertion macros shared by the HSV to RGB converter RTL.
// No dependencies; the checks drop out when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// A property that must hold at every clock edge out of reset.
`define ASSERT_HOLDS(label, clk_i, rst_i, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (rst_i) (prop)) else $error(msg);
// An implication checked in the same cycle.
`define ASSERT_IMPLIES(label, clk_i, rst_i, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (rst_i) (ante) |-> (cons)) \
    else $error(msg);
`else
`define ASSERT_HOLDS(label, clk_i, rst_i, prop, msg)
`define ASSERT_IMPLIES(label, clk_i, rst_i, ante, cons, msg)
`endif

`endif

// ----- design/hsv2rgb_pkg.sv -----
// Shared types and constants of the HSV to RGB converter.
// No dependencies.
package hsv2rgb_pkg;

  localparam int DEF_FRAC_BITS = 16;
  localparam int DEF_INT_BITS  = 8;

  typedef logic [2:0] sector_t;

  // Hue sectors, one sixth of a turn each.
  localparam sector_t SECT_RY = 3'd0;
  localparam sector_t SECT_YG = 3'd1;
  localparam sector_t SECT_GC = 3'd2;
  localparam sector_t SECT_CB = 3'd3;
  localparam sector_t SECT_BM = 3'd4;
  localparam sector_t SECT_MR = 3'd5;

endpackage

// ----- design/hsv2rgb_prep.sv -----
// First pipeline stage: clamps saturation, value and alpha (1.0 when none is given) and splits the hue.
// Depends on hsv2rgb_pkg.
module hsv2rgb_prep #(
  parameter int FRAC_BITS = 16,
  parameter int INT_BITS  = 8
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [INT_BITS+FRAC_BITS-1:0] hue,
  input  logic [INT_BITS+FRAC_BITS-1:0] sat,
  input  logic [INT_BITS+FRAC_BITS-1:0] val,
  input  logic [INT_BITS+FRAC_BITS-1:0] alpha_in,
  input  logic                     alpha_given,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [FRAC_BITS:0]       sat_q,
  output logic [FRAC_BITS:0]       val_q,
  output logic [FRAC_BITS:0]       alpha_q,
  output hsv2rgb_pkg::sector_t     sector,
  output logic [FRAC_BITS-1:0]     frac
);
  import hsv2rgb_pkg::*;

  localparam int W = INT_BITS + FRAC_BITS;
  localparam logic [FRAC_BITS:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic [W-1:0] ONE_W = {{(W-FRAC_BITS-1){1'b0}}, ONE};

  // Negative values go to zero, anything above 1.0 goes to 1.0.
  function automatic logic [FRAC_BITS:0] clamp_unit(input logic [W-1:0] raw);
    logic [FRAC_BITS:0] res;
    begin
      if (raw[W-1]) begin
        res = '0;
      end else if (raw > ONE_W) begin
        res = ONE;
      end else begin
        res = raw[FRAC_BITS:0];
      end
      return res;
    end
  endfunction

  logic [FRAC_BITS-1:0] hue_frac;
  logic [FRAC_BITS+2:0] hue6;

  // The fraction of |hue| only needs the low bits of the negation.
  assign hue_frac = hue[W-1] ? (FRAC_BITS'(0) - hue[FRAC_BITS-1:0]) : hue[FRAC_BITS-1:0];
  assign hue6 = (FRAC_BITS+3)'({hue_frac, 2'b00}) + (FRAC_BITS+3)'({hue_frac, 1'b0});

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
    if (in_valid && in_ready) begin
      sat_q   <= clamp_unit(sat);
      val_q   <= clamp_unit(val);
      alpha_q <= alpha_given ? clamp_unit(alpha_in) : ONE;
      sector  <= sector_t'(hue6[FRAC_BITS+2:FRAC_BITS]);
      frac    <= hue6[FRAC_BITS-1:0];
    end
  end

endmodule

// ----- design/hsv2rgb_coef.sv -----
// Second pipeline stage: forms the scale factors 1-s, 1-s*f and 1-s*(1-f).
// Depends on hsv2rgb_pkg.
module hsv2rgb_coef #(
  parameter int FRAC_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [FRAC_BITS:0]   sat_in,
  input  logic [FRAC_BITS:0]   val_in,
  input  logic [FRAC_BITS:0]   alpha_in,
  input  hsv2rgb_pkg::sector_t sector_in,
  input  logic [FRAC_BITS-1:0] frac_in,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [FRAC_BITS:0]   val_q,
  output logic [FRAC_BITS:0]   alpha_q,
  output hsv2rgb_pkg::sector_t sector_q,
  output logic [FRAC_BITS:0]   kp,
  output logic [FRAC_BITS:0]   kq,
  output logic [FRAC_BITS:0]   kt
);
  import hsv2rgb_pkg::*;

  localparam int PW = 2 * FRAC_BITS + 1;
  localparam logic [FRAC_BITS:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

  logic [FRAC_BITS:0] one_minus_f;
  logic [PW-1:0]      prod_sf;
  logic [PW-1:0]      prod_sfn;

  // Both products stay at or below 1.0 squared, so 2F+1 bits hold them.
  assign one_minus_f = ONE - {1'b0, frac_in};
  assign prod_sf     = PW'(sat_in) * PW'(frac_in);
  assign prod_sfn    = PW'(sat_in) * PW'(one_minus_f);

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
    if (in_valid && in_ready) begin
      val_q    <= val_in;
      alpha_q  <= alpha_in;
      sector_q <= sector_in;
      kp       <= ONE - sat_in;
      kq       <= ONE - prod_sf[PW-1:FRAC_BITS];
      kt       <= ONE - prod_sfn[PW-1:FRAC_BITS];
    end
  end

endmodule

// ----- design/hsv2rgb_shade.sv -----
// Third pipeline stage: scales the value by each factor to give p, q and t.
// Depends on hsv2rgb_pkg.
module hsv2rgb_shade #(
  parameter int FRAC_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [FRAC_BITS:0]   val_in,
  input  logic [FRAC_BITS:0]   alpha_in,
  input  hsv2rgb_pkg::sector_t sector_in,
  input  logic [FRAC_BITS:0]   kp,
  input  logic [FRAC_BITS:0]   kq,
  input  logic [FRAC_BITS:0]   kt,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [FRAC_BITS:0]   val_q,
  output logic [FRAC_BITS:0]   alpha_q,
  output hsv2rgb_pkg::sector_t sector_q,
  output logic [FRAC_BITS:0]   p,
  output logic [FRAC_BITS:0]   q,
  output logic [FRAC_BITS:0]   t
);
  import hsv2rgb_pkg::*;

  localparam int PW = 2 * FRAC_BITS + 1;

  logic [PW-1:0] prod_p;
  logic [PW-1:0] prod_q;
  logic [PW-1:0] prod_t;

  assign prod_p = PW'(val_in) * PW'(kp);
  assign prod_q = PW'(val_in) * PW'(kq);
  assign prod_t = PW'(val_in) * PW'(kt);

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
    if (in_valid && in_ready) begin
      val_q    <= val_in;
      alpha_q  <= alpha_in;
      sector_q <= sector_in;
      p        <= prod_p[PW-1:FRAC_BITS];
      q        <= prod_q[PW-1:FRAC_BITS];
      t        <= prod_t[PW-1:FRAC_BITS];
    end
  end

endmodule

// ----- design/hsv2rgb_swizzle.sv -----
// Output stage: routes v, p, q and t to red, green and blue by hue sector.
// Depends on hsv2rgb_pkg.
module hsv2rgb_swizzle #(
  parameter int FRAC_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [FRAC_BITS:0]   val_in,
  input  logic [FRAC_BITS:0]   alpha_in,
  input  hsv2rgb_pkg::sector_t sector_in,
  input  logic [FRAC_BITS:0]   p,
  input  logic [FRAC_BITS:0]   q,
  input  logic [FRAC_BITS:0]   t,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [FRAC_BITS:0]   red,
  output logic [FRAC_BITS:0]   green,
  output logic [FRAC_BITS:0]   blue,
  output logic [FRAC_BITS:0]   alpha_out
);
  import hsv2rgb_pkg::*;

  logic [FRAC_BITS:0] red_next;
  logic [FRAC_BITS:0] green_next;
  logic [FRAC_BITS:0] blue_next;

  always_comb begin
    case (sector_in)
      SECT_RY: begin
        red_next = val_in; green_next = t;      blue_next = p;
      end
      SECT_YG: begin
        red_next = q;      green_next = val_in; blue_next = p;
      end
      SECT_GC: begin
        red_next = p;      green_next = val_in; blue_next = t;
      end
      SECT_CB: begin
        red_next = p;      green_next = q;      blue_next = val_in;
      end
      SECT_BM: begin
        red_next = t;      green_next = p;      blue_next = val_in;
      end
      default: begin
        red_next = val_in; green_next = p;      blue_next = q;
      end
    endcase
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
    if (in_valid && in_ready) begin
      red       <= red_next;
      green     <= green_next;
      blue      <= blue_next;
      alpha_out <= alpha_in;
    end
  end

endmodule

// ----- design/hsv_to_rgb_converter.sv -----
// Top level of the HSV(A) to RGBA converter: a four-stage pipeline.
// Depends on hsv2rgb_pkg, assert_macros.svh and the hsv2rgb_* stage modules.
//
//   Channel  Direction  Handshake           Contents
//   s_*      in         s_tvalid/s_tready   one HSV color request, optional alpha
//   m_*      out        m_tvalid/m_tready   one RGBA color per request
//
// A request accepted on s_* passes in order through the four register stages (clamp
// and hue split, factor products, value products, sector routing); once in the
// output register it sits on m_tdata until it is taken. One request is taken every
// cycle while m_tready does not stall the output. Reset clears the valid bit of
// every stage, so the pipeline comes up empty. A stall on m_tready holds each full
// stage in place and pulls s_tready low only once all four stages are full; nothing
// is lost or repeated.
`include "assert_macros.svh"

module hsv_to_rgb_converter #(
  parameter int FRAC_BITS = hsv2rgb_pkg::DEF_FRAC_BITS,
  parameter int INT_BITS  = hsv2rgb_pkg::DEF_INT_BITS,
  localparam int IN_W       = INT_BITS + FRAC_BITS,
  localparam int OUT_W      = FRAC_BITS + 1,
  localparam int IN_DATA_W  = ((4 * IN_W + 7) / 8) * 8,
  localparam int OUT_DATA_W = ((4 * OUT_W + 7) / 8) * 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // From bit 0 up: hue, sat, val, alpha_in (each IN_W bits, signed), zero fill.
  input  logic [IN_DATA_W-1:0]  s_tdata,
  // Bit 0: alpha_given.
  input  logic                  s_tuser,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // From bit 0 up: red, green, blue, alpha_out (each OUT_W bits), zero fill.
  output logic [OUT_DATA_W-1:0] m_tdata
);
  import hsv2rgb_pkg::*;

  localparam logic [FRAC_BITS:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

  // Unpacked request fields.
  logic [IN_W-1:0] hue;
  logic [IN_W-1:0] sat;
  logic [IN_W-1:0] val;
  logic [IN_W-1:0] alpha_in;

  assign hue      = s_tdata[IN_W-1:0];
  assign sat      = s_tdata[2*IN_W-1:IN_W];
  assign val      = s_tdata[3*IN_W-1:2*IN_W];
  assign alpha_in = s_tdata[4*IN_W-1:3*IN_W];

  // Stage 1 to stage 2: clamped operands, hue sector and fraction.
  logic                 prep_valid;
  logic                 prep_ready;
  logic [FRAC_BITS:0]   prep_sat;
  logic [FRAC_BITS:0]   prep_val;
  logic [FRAC_BITS:0]   prep_alpha;
  sector_t              prep_sector;
  logic [FRAC_BITS-1:0] prep_frac;

  // Stage 2 to stage 3: the three scale factors.
  logic                 coef_valid;
  logic                 coef_ready;
  logic [FRAC_BITS:0]   coef_val;
  logic [FRAC_BITS:0]   coef_alpha;
  sector_t              coef_sector;
  logic [FRAC_BITS:0]   coef_kp;
  logic [FRAC_BITS:0]   coef_kq;
  logic [FRAC_BITS:0]   coef_kt;

  // Stage 3 to stage 4: p, q and t.
  logic                 shade_valid;
  logic                 shade_ready;
  logic [FRAC_BITS:0]   shade_val;
  logic [FRAC_BITS:0]   shade_alpha;
  sector_t              shade_sector;
  logic [FRAC_BITS:0]   shade_p;
  logic [FRAC_BITS:0]   shade_q;
  logic [FRAC_BITS:0]   shade_t;

  // Output register contents.
  logic [FRAC_BITS:0]   red;
  logic [FRAC_BITS:0]   green;
  logic [FRAC_BITS:0]   blue;
  logic [FRAC_BITS:0]   alpha_out;

  hsv2rgb_prep #(
    .FRAC_BITS (FRAC_BITS),
    .INT_BITS  (INT_BITS)
  ) u_prep (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s_tvalid),
    .in_ready    (s_tready),
    .hue         (hue),
    .sat         (sat),
    .val         (val),
    .alpha_in    (alpha_in),
    .alpha_given (s_tuser),
    .out_valid   (prep_valid),
    .out_ready   (prep_ready),
    .sat_q       (prep_sat),
    .val_q       (prep_val),
    .alpha_q     (prep_alpha),
    .sector      (prep_sector),
    .frac        (prep_frac)
  );

  hsv2rgb_coef #(
    .FRAC_BITS (FRAC_BITS)
  ) u_coef (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (prep_valid),
    .in_ready  (prep_ready),
    .sat_in    (prep_sat),
    .val_in    (prep_val),
    .alpha_in  (prep_alpha),
    .sector_in (prep_sector),
    .frac_in   (prep_frac),
    .out_valid (coef_valid),
    .out_ready (coef_ready),
    .val_q     (coef_val),
    .alpha_q   (coef_alpha),
    .sector_q  (coef_sector),
    .kp        (coef_kp),
    .kq        (coef_kq),
    .kt        (coef_kt)
  );

  // With zero saturation every factor is 1.0, so p, q and t all equal the
  // value and the result comes out grey without a separate path.
  hsv2rgb_shade #(
    .FRAC_BITS (FRAC_BITS)
  ) u_shade (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (coef_valid),
    .in_ready  (coef_ready),
    .val_in    (coef_val),
    .alpha_in  (coef_alpha),
    .sector_in (coef_sector),
    .kp        (coef_kp),
    .kq        (coef_kq),
    .kt        (coef_kt),
    .out_valid (shade_valid),
    .out_ready (shade_ready),
    .val_q     (shade_val),
    .alpha_q   (shade_alpha),
    .sector_q  (shade_sector),
    .p         (shade_p),
    .q         (shade_q),
    .t         (shade_t)
  );

  hsv2rgb_swizzle #(
    .FRAC_BITS (FRAC_BITS)
  ) u_swizzle (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (shade_valid),
    .in_ready  (shade_ready),
    .val_in    (shade_val),
    .alpha_in  (shade_alpha),
    .sector_in (shade_sector),
    .p         (shade_p),
    .q         (shade_q),
    .t         (shade_t),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .red       (red),
    .green     (green),
    .blue      (blue),
    .alpha_out (alpha_out)
  );

  assign m_tdata = OUT_DATA_W'({alpha_out, blue, green, red});

  // Every channel of a finished result lies in the unit range; red and alpha are checked.
  `ASSERT_IMPLIES(a_red_range, clk, rst, m_tvalid, red <= ONE, "red above 1.0")
  `ASSERT_IMPLIES(a_alpha_range, clk, rst, m_tvalid, alpha_out <= ONE, "alpha above 1.0")
  // The hue split never yields a sector beyond the sixth.
  `ASSERT_IMPLIES(a_sector_range, clk, rst, prep_valid, prep_sector <= SECT_MR,
                  "hue sector out of range")
  // Back-pressure reaches the input only when the whole pipeline is full and stalled.
  `ASSERT_IMPLIES(a_stall_cause, clk, rst, !s_tready,
                  m_tvalid && !m_tready && prep_valid && coef_valid && shade_valid,
                  "input stalled while the pipeline has room")

endmodule
